// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the Huffman tree bit decoder.
// Needs no other file; the checks fall away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property check on clk_i, switched off while rst_ni is low.
`define HTBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define HTBD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define HTBD_ASSERT(label, prop, msg)
`define HTBD_NEVER(label, cond, msg)

`endif

`endif

// ----- sv/htbd_pkg.sv -----
// Types and constants of the Huffman tree bit decoder.
// Has no dependencies; imported by huffman_tree_bit_decoder_top.
package htbd_pkg;

  localparam int IDX_W    = 9;
  localparam int SYM_IN_W = 8;
  localparam int OP_W     = 2;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  // Register index, taken from the word-address bit of paddr.
  localparam logic REG_ROOT_INDEX = 1'b0;

endpackage

// ----- sv/huffman_tree_bit_decoder_top.sv -----
// Top level of the Huffman tree bit decoder: node table memory and tree walk.
// Depends on htbd_pkg and on assert_macros.svh.

// The decoder walks a Huffman tree held in a node table of NODE_COUNT entries, one
// code bit per input beat. Write beats load table entries, decode beats carry one
// code bit each and restart beats drop a partial walk. When a walk reaches a leaf,
// one output beat carries its symbol, which passes the second stage of the decode
// beat that got there and is then registered; a decode beat that stops at an inner
// node and all other beats produce no output beat. The sustained rate is one input
// beat per cycle while input is not stalled, set by the single read port of the
// node table: every decode beat from an inner node reads the child node that its
// bit selects, and the node read for one beat is forwarded straight into the child
// selection of the next beat. The root entry sits in a shadow register that write
// beats to the root keep up to date; after a write to root_index no input beat is
// taken until the new root entry is read from the table. The output has a result
// register and a skid register, so input beats keep flowing while a symbol waits
// to be taken; input stalls once both are spoken for, with a pending decode as one.
// Reading a table entry that was never written gives an undefined symbol.
`include "assert_macros.svh"

module huffman_tree_bit_decoder_top #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [htbd_pkg::OP_W-1:0]     opcode_i,
  input  logic [htbd_pkg::IDX_W-1:0]    node_index_i,
  input  logic                          node_is_leaf_i,
  input  logic [htbd_pkg::IDX_W-1:0]    zero_child_i,
  input  logic [htbd_pkg::IDX_W-1:0]    one_child_i,
  input  logic [htbd_pkg::SYM_IN_W-1:0] leaf_symbol_i,
  input  logic                          code_bit_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [SYMBOL_BITS-1:0]        symbol_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [htbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [htbd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import htbd_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  // One node of the tree as it is stored in the table.
  typedef struct packed {
    logic                   leaf;
    idx_t                   zero_child;
    idx_t                   one_child;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam node_t NODE_ZERO = '0;

  // True when an index lies inside the table. Indices beyond it read as an
  // inner node with both children at zero, and writes to them are dropped.
  function automatic logic in_table(idx_t idx);
    return int'(idx) < NODE_COUNT;
  endfunction

  function automatic logic [AW-1:0] to_addr(idx_t idx);
    return AW'(idx);
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  idx_t                   root_q, root_d;
  node_t                  root_entry_q, root_entry_d;
  logic                   active_q, active_d;
  idx_t                   pos_q, pos_d;
  node_t                  cur_entry_q, cur_entry_d;

  // Second stage of a decode beat: its child's table read, if any, is in flight.
  logic                   b_valid_q, b_valid_d;
  logic                   b_direct_q, b_direct_d;
  logic [SYMBOL_BITS-1:0] b_sym_q, b_sym_d;
  idx_t                   b_next_q, b_next_d;

  // Root refresh after a write to root_index: read cycle, then data cycle.
  logic                   refresh_q, refresh_d;
  logic                   refresh_rd_q, refresh_rd_d;

  logic                   rd_oor_q, rd_oor_d;

  logic                   out_vld_q, out_vld_d;
  logic [SYMBOL_BITS-1:0] out_sym_q, out_sym_d;
  logic                   skid_vld_q, skid_vld_d;
  logic [SYMBOL_BITS-1:0] skid_sym_q, skid_sym_d;

  // ---------------------------------------------------------------------------
  // Node table
  // ---------------------------------------------------------------------------
  node_t           mem [NODE_COUNT];
  node_t           rdata_q;
  logic            mem_we;
  logic            mem_re;
  idx_t            mem_ridx;
  node_t           wr_node;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[to_addr(node_index_i)] <= wr_node;
    end
    if (mem_re) begin
      rdata_q <= mem[to_addr(mem_ridx)];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes and configuration
  // ---------------------------------------------------------------------------
  opcode_e          op;
  logic             in_accept;
  logic             pop;
  logic [1:0]       occ;
  logic [1:0]       load;
  logic             cfg_we;

  assign op        = opcode_e'(opcode_i);
  assign in_accept = in_valid_i & ~in_stall_o;
  assign pop       = out_vld_q & ~out_stall_i;

  // Symbols already held plus the one a pending decode may still produce,
  // less the one leaving this cycle. A beat taken now can add one more.
  assign occ  = {1'b0, out_vld_q} + {1'b0, skid_vld_q} + {1'b0, b_valid_q};
  assign load = occ - {1'b0, pop};

  assign in_stall_o = refresh_q | refresh_rd_q | (load >= 2'd2);

  assign cfg_we = psel & penable & pwrite & (paddr[PADDR_W-1] == REG_ROOT_INDEX);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_ROOT_INDEX) ? PDATA_W'(root_q) : '0;

  assign out_valid_o = out_vld_q;
  assign symbol_o    = out_sym_q;

  // ---------------------------------------------------------------------------
  // Tree walk
  // ---------------------------------------------------------------------------
  node_t                  rd_node;
  node_t                  eff_entry;
  node_t                  start_entry;
  logic                   eff_active;
  idx_t                   eff_pos;
  idx_t                   next_idx;
  logic                   res_valid;
  logic [SYMBOL_BITS-1:0] res_sym;
  logic                   wr_hit;

  assign rd_node = rd_oor_q ? NODE_ZERO : rdata_q;

  always_comb begin
    wr_node.leaf       = node_is_leaf_i;
    wr_node.zero_child = zero_child_i;
    wr_node.one_child  = one_child_i;
    wr_node.sym        = SYMBOL_BITS'(leaf_symbol_i);
  end

  assign wr_hit = in_table(node_index_i);

  // The decode beat in its second stage settles first: its child node has just
  // come out of the table, and the walk state it leaves is what the beat being
  // taken in this cycle starts from.
  always_comb begin
    res_valid  = 1'b0;
    res_sym    = '0;
    eff_active = active_q;
    eff_pos    = pos_q;
    eff_entry  = cur_entry_q;
    if (b_valid_q) begin
      if (b_direct_q) begin
        res_valid  = 1'b1;
        res_sym    = b_sym_q;
        eff_active = 1'b0;
        eff_pos    = '0;
      end else if (rd_node.leaf) begin
        res_valid  = 1'b1;
        res_sym    = rd_node.sym;
        eff_active = 1'b0;
        eff_pos    = '0;
      end else begin
        eff_active = 1'b1;
        eff_pos    = b_next_q;
        eff_entry  = rd_node;
      end
    end
  end

  assign start_entry = eff_active ? eff_entry : root_entry_q;
  assign next_idx    = code_bit_i ? start_entry.one_child : start_entry.zero_child;

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_ridx     = next_idx;
    active_d     = eff_active;
    pos_d        = eff_pos;
    cur_entry_d  = eff_entry;
    root_entry_d = root_entry_q;
    b_valid_d    = 1'b0;
    b_direct_d   = b_direct_q;
    b_sym_d      = b_sym_q;
    b_next_d     = b_next_q;
    root_d       = root_q;
    refresh_d    = cfg_we;
    refresh_rd_d = refresh_q;
    rd_oor_d     = rd_oor_q;

    if (cfg_we) begin
      root_d = pwdata[IDX_W-1:0];
    end

    if (refresh_q) begin
      mem_re   = 1'b1;
      mem_ridx = root_q;
    end
    if (refresh_rd_q) begin
      root_entry_d = rd_node;
    end

    if (in_accept) begin
      unique case (op)
        OP_WRITE: begin
          if (wr_hit) begin
            mem_we = 1'b1;
            // Keep the copies of the current node and of the root coherent.
            if (eff_active && (node_index_i == eff_pos)) begin
              cur_entry_d = wr_node;
            end
            if (node_index_i == root_q) begin
              root_entry_d = wr_node;
            end
          end
        end
        OP_RESTART: begin
          active_d = 1'b0;
          pos_d    = '0;
        end
        OP_DECODE: begin
          b_valid_d  = 1'b1;
          b_direct_d = start_entry.leaf;
          b_sym_d    = start_entry.sym;
          b_next_d   = next_idx;
          if (!start_entry.leaf) begin
            mem_re = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (mem_re) begin
      rd_oor_d = ~in_table(mem_ridx);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_vld_d  = out_vld_q;
    out_sym_d  = out_sym_q;
    skid_vld_d = skid_vld_q;
    skid_sym_d = skid_sym_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_sym_d  = skid_sym_q;
        skid_vld_d = res_valid;
        skid_sym_d = res_sym;
      end else begin
        out_vld_d = res_valid;
        out_sym_d = res_sym;
      end
    end else if (!out_vld_q) begin
      out_vld_d = res_valid;
      out_sym_d = res_sym;
    end else if (res_valid) begin
      skid_vld_d = 1'b1;
      skid_sym_d = res_sym;
    end
  end

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q       <= '0;
      active_q     <= 1'b0;
      pos_q        <= '0;
      b_valid_q    <= 1'b0;
      refresh_q    <= 1'b0;
      refresh_rd_q <= 1'b0;
      rd_oor_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      skid_vld_q   <= 1'b0;
    end else begin
      root_q       <= root_d;
      active_q     <= active_d;
      pos_q        <= pos_d;
      b_valid_q    <= b_valid_d;
      refresh_q    <= refresh_d;
      refresh_rd_q <= refresh_rd_d;
      rd_oor_q     <= rd_oor_d;
      out_vld_q    <= out_vld_d;
      skid_vld_q   <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_entry_q <= root_entry_d;
    cur_entry_q  <= cur_entry_d;
    b_direct_q   <= b_direct_d;
    b_sym_q      <= b_sym_d;
    b_next_q     <= b_next_d;
    out_sym_q    <= out_sym_d;
    skid_sym_q   <= skid_sym_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HTBD_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid register full while output register empty")
  `HTBD_NEVER(a_result_overflow, res_valid && out_vld_q && skid_vld_q && !pop, "symbol produced with no room left")
  `HTBD_NEVER(a_refresh_blocks_input, (refresh_q || refresh_rd_q) && in_accept, "input beat taken during root refresh")
  `HTBD_ASSERT(a_decode_tracked, (in_accept && (op == OP_DECODE)) |=> b_valid_q, "decode beat lost its second stage")
  `HTBD_NEVER(a_port_clash, mem_we && mem_re, "node table read and written in one cycle")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for huffman_tree_bit_decoder_top: random trees and bit streams.
// Depends on htbd_pkg and the decoder RTL; a small scoreboard class predicts every symbol beat.

import htbd_pkg::*;

// One input beat, one field per port of the input channel.
typedef struct packed {
  logic [OP_W-1:0]     op;
  idx_t                node;
  logic                leaf;
  idx_t                child0;
  idx_t                child1;
  logic [SYM_IN_W-1:0] sym;
  logic                code_bit;
} tree_beat_t;

// Mirror of the node table and the tree walk. Every accepted input beat is
// applied to the mirror, and each decode beat that lands on a leaf queues the
// symbol that the decoder must put out next.
class symbol_scoreboard;
  idx_t                root;
  idx_t                walk_pos;
  bit                  walk_on;
  bit                  written [512];
  bit                  is_leaf [512];
  idx_t                kid0 [512];
  idx_t                kid1 [512];
  logic [SYM_IN_W-1:0] leaf_sym [512];
  logic [SYM_IN_W-1:0] expected_symbols [$];
  int                  errors;

  // The node the next code bit starts from.
  function idx_t start_node();
    return walk_on ? walk_pos : root;
  endfunction

  function void note_beat(tree_beat_t b);
    idx_t cur;
    bit   hit;
    case (b.op)
      OP_WRITE: begin
        written[b.node]  = 1'b1;
        is_leaf[b.node]  = b.leaf;
        kid0[b.node]     = b.child0;
        kid1[b.node]     = b.child1;
        leaf_sym[b.node] = b.sym;
      end
      OP_RESTART: begin
        walk_on  = 1'b0;
        walk_pos = '0;
      end
      OP_DECODE: begin
        cur = start_node();
        // A walk that already stands on a leaf emits it without using the bit.
        hit = is_leaf[cur];
        if (!hit) begin
          cur = b.code_bit ? kid1[cur] : kid0[cur];
          hit = is_leaf[cur];
        end
        if (hit) begin
          expected_symbols = {expected_symbols, leaf_sym[cur]};
          walk_on  = 1'b0;
          walk_pos = '0;
        end else begin
          walk_pos = cur;
          walk_on  = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_symbol(logic [SYM_IN_W-1:0] got);
    logic [SYM_IN_W-1:0] want;
    if (expected_symbols.size() == 0) begin
      $error("symbol: no beat expected, actual %0h", got);
      errors++;
    end else begin
      want = expected_symbols.pop_front();
      if (got !== want) begin
        $error("symbol: expected %0h, actual %0h", want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  // Wait after the last expected symbol, so that the decoder is idle.
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;
  localparam int BEAT_TARGET    = 900;

  // The one opcode that the package leaves without a name.
  localparam logic [OP_W-1:0]    OP_UNUSED       = 2'd3;
  localparam logic [PADDR_W-1:0] ROOT_INDEX_ADDR = {REG_ROOT_INDEX, 2'b00};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [OP_W-1:0]        opcode_i;
  idx_t                   node_index_i;
  logic                   node_is_leaf_i;
  idx_t                   zero_child_i;
  idx_t                   one_child_i;
  logic [SYM_IN_W-1:0]    leaf_symbol_i;
  logic                   code_bit_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SYM_IN_W-1:0]    symbol_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  symbol_scoreboard sb;

  // Idling of both channels, in percent of cycles; changed between phases only.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // The main process asks for a long receiver hold-off by raising holds_asked;
  // the receiver process counts the hold-off itself.
  int holds_asked    = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int beats_sent     = 0;
  int idle_cycles    = 0;
  // Every node of the tree loaded last, used as children by stray write beats.
  idx_t tree_nodes [$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  huffman_tree_bit_decoder_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .node_is_leaf_i (node_is_leaf_i),
    .zero_child_i   (zero_child_i),
    .one_child_i    (one_child_i),
    .leaf_symbol_i  (leaf_symbol_i),
    .code_bit_i     (code_bit_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Receiver. Outputs are sampled at the rising edge, before any register of
  // the decoder has moved, and the stall for the next cycle is driven with a
  // nonblocking assignment at that same edge. During a requested hold-off the
  // stall stays high until hold_left has counted down from HOLD_CYCLES, so that
  // the result and skid registers fill up and the decoder has to stall its input.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_symbol(symbol_o);
    end
    if (holds_asked != holds_done) begin
      holds_done  <= holds_done + 1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any beat on either channel, or a register access, counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offers one beat and returns at the edge that accepts it. An idle gap of
  // random length may come first; valid is only lowered when a gap is taken,
  // so back-to-back beats keep it high without a glitch.
  task automatic send_beat(input tree_beat_t b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= b.op;
    node_index_i   <= b.node;
    node_is_leaf_i <= b.leaf;
    zero_child_i   <= b.child0;
    one_child_i    <= b.child1;
    leaf_symbol_i  <= b.sym;
    code_bit_i     <= b.code_bit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_beat(b);
    beats_sent++;
  endtask

  // Lets every expected symbol come out, then waits out the decoder latency,
  // so that the block is idle for a register write.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready is seen.
  task automatic write_root(input idx_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_INDEX_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.root = value;
  endtask

  function automatic tree_beat_t make_beat(input logic [OP_W-1:0] op, input idx_t node,
                                           input logic leaf, input idx_t child0,
                                           input idx_t child1, input logic [SYM_IN_W-1:0] sym,
                                           input logic code_bit);
    tree_beat_t b;
    b.op       = op;
    b.node     = node;
    b.leaf     = leaf;
    b.child0   = child0;
    b.child1   = child1;
    b.sym      = sym;
    b.code_bit = code_bit;
    return b;
  endfunction

  // A beat of the given opcode with every other field random, whether or not
  // the opcode uses it.
  function automatic tree_beat_t scramble(input logic [OP_W-1:0] op);
    return make_beat(op, idx_t'($urandom_range(511)), 1'($urandom_range(1)),
                     idx_t'($urandom_range(511)), idx_t'($urandom_range(511)),
                     SYM_IN_W'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  // A decode beat that never makes the decoder read an entry that was never
  // written. If the random bit leads to such an entry the other bit is used,
  // and if neither will do, the walk is restarted instead.
  function automatic tree_beat_t next_decode();
    tree_beat_t b;
    idx_t       cur;
    b   = scramble(OP_DECODE);
    cur = sb.start_node();
    if (!sb.written[cur]) begin
      b.op = OP_RESTART;
    end else if (!sb.is_leaf[cur]) begin
      if (!sb.written[b.code_bit ? sb.kid1[cur] : sb.kid0[cur]]) b.code_bit = !b.code_bit;
      if (!sb.written[b.code_bit ? sb.kid1[cur] : sb.kid0[cur]]) b.op = OP_RESTART;
    end
    return b;
  endfunction

  // Grows a random full binary tree from the given root by splitting random
  // leaves, writing each inner node as it is split and the leaves at the end.
  // A tree of one leaf is a root that is itself a leaf.
  task automatic load_tree(input idx_t top, input int leaves);
    idx_t       open_q [$];
    bit         taken [512];
    idx_t       n;
    idx_t       zero_idx;
    idx_t       one_idx;
    tree_beat_t b;
    int         k;
    tree_nodes.delete();
    taken[top] = 1'b1;
    open_q = {open_q, top};
    while (open_q.size() < leaves) begin
      k = $urandom_range(open_q.size() - 1);
      n = open_q[k];
      open_q.delete(k);
      do zero_idx = idx_t'($urandom_range(511)); while (taken[zero_idx]);
      taken[zero_idx] = 1'b1;
      do one_idx = idx_t'($urandom_range(511)); while (taken[one_idx]);
      taken[one_idx] = 1'b1;
      b        = scramble(OP_WRITE);
      b.node   = n;
      b.leaf   = 1'b0;
      b.child0 = zero_idx;
      b.child1 = one_idx;
      send_beat(b);
      tree_nodes = {tree_nodes, n};
      open_q     = {open_q, zero_idx, one_idx};
    end
    foreach (open_q[i]) begin
      b      = scramble(OP_WRITE);
      b.node = open_q[i];
      b.leaf = 1'b1;
      send_beat(b);
      tree_nodes = {tree_nodes, open_q[i]};
    end
  endtask

  // Mostly well-formed code bits, with restarts, unused opcodes and stray
  // table writes mixed in. Stray writes point their children at nodes of the
  // current tree, so that no walk can run into an entry that was never written.
  task automatic run_stream(input int count);
    tree_beat_t b;
    int         r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 86) begin
        b = next_decode();
      end else if (r < 91) begin
        b = scramble(OP_RESTART);
      end else if (r < 95) begin
        b = scramble(OP_UNUSED);
      end else begin
        b        = scramble(OP_WRITE);
        b.child0 = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
        b.child1 = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
      end
      send_beat(b);
    end
  endtask

  // Directed opening, with the root at its reset value of 0: a root that is a
  // leaf, the unused opcode, a small tree whose nodes and symbols sit at the
  // extremes, a restart in the middle of a code, and a leaf written at the very
  // node where a walk has stopped.
  task automatic run_directed();
    tree_beat_t script [$];
    script = {script, make_beat(OP_WRITE,   9'd0,   1'b1, 9'd511, 9'd0,   8'hA5, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd511, 1'b1, 9'd511, 9'd511, 8'hFF, 1'b1)};
    script = {script, make_beat(OP_UNUSED,  9'd511, 1'b1, 9'd511, 9'd511, 8'hFF, 1'b1)};
    script = {script, make_beat(OP_RESTART, 9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    script = {script, make_beat(OP_WRITE,   9'd511, 1'b1, 9'd511, 9'd511, 8'hFF, 1'b0)};
    script = {script, make_beat(OP_WRITE,   9'd2,   1'b1, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_WRITE,   9'd1,   1'b0, 9'd2,   9'd511, 8'h5A, 1'b0)};
    script = {script, make_beat(OP_WRITE,   9'd0,   1'b0, 9'd511, 9'd1,   8'h00, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_RESTART, 9'd511, 1'b1, 9'd511, 9'd511, 8'hFF, 1'b1)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b1)};
    script = {script, make_beat(OP_WRITE,   9'd1,   1'b1, 9'd0,   9'd0,   8'h3C, 1'b0)};
    script = {script, make_beat(OP_DECODE,  9'd0,   1'b0, 9'd0,   9'd0,   8'h00, 1'b0)};
    foreach (script[i]) send_beat(script[i]);
  endtask

  initial begin
    int   phase;
    int   leaves;
    idx_t top;
    sb             = new;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_RESTART;
    node_index_i   = '0;
    node_is_leaf_i = 1'b0;
    zero_child_i   = '0;
    one_child_i    = '0;
    leaf_symbol_i  = '0;
    code_bit_i     = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    settle();

    // Random phases. Each loads a fresh tree, moves the root to it while the
    // decoder is idle and then streams code bits under one idling pattern.
    // The root cycles through the top index, index 0 and a random one. The
    // first phase is the pressure phase: a root with two leaf children makes
    // every decode beat yield a symbol while the receiver holds off.
    phase = 0;
    while (beats_sent < BEAT_TARGET) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      if (phase == 0) begin
        leaves = 2;
      end else if ($urandom_range(9) == 0) begin
        leaves = $urandom_range(60, 25);
      end else begin
        leaves = $urandom_range(12, 1);
      end
      case (phase % 3)
        0: top = idx_t'(511);
        1: top = idx_t'(0);
        default: top = idx_t'($urandom_range(511));
      endcase
      load_tree(top, leaves);
      settle();
      write_root(top);
      if (phase == 0) holds_asked <= holds_asked + 1;
      run_stream($urandom_range(120, 40));
      settle();
      phase++;
    end

    if (sb.errors == 0 && sb.expected_symbols.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
